/* hdl/json_string_unescape_utf8_defines.svh */
// assertion helpers shared by the decoder files
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define JSU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define JSU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/jsu_pkg.sv */
`timescale 1ns / 1ps

package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_HEX1    = 3'd2,
    MODE_WANT_BS = 3'd3,
    MODE_WANT_U  = 3'd4,
    MODE_HEX2    = 3'd5,
    MODE_DONE    = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_CLOSED  = 3'd1,
    KIND_BAD_ESC = 3'd2,
    KIND_BAD_HEX = 3'd3,
    KIND_NO_LOW  = 3'd4,
    KIND_UNTERM  = 3'd5
  } kind_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
  localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;

  // results caused by one item: count, bytes in output order, shared kind
  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] bytes;
    kind_t           kind;
  } res_pack_t;

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = {1'b0, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      v = {1'b0, b[3:0] + 4'd9};
    end
    return v;
  endfunction

  // bit 8 set means unknown escape letter
  function automatic logic [8:0] esc_char(input logic [7:0] b);
    logic [8:0] c;
    unique case (b)
      CH_BSLASH: c = {1'b0, CH_BSLASH};
      CH_SLASH:  c = {1'b0, CH_SLASH};
      CH_QUOTE:  c = {1'b0, CH_QUOTE};
      8'h74:     c = 9'h009;
      8'h6E:     c = 9'h00A;
      8'h72:     c = 9'h00D;
      8'h66:     c = 9'h00C;
      8'h62:     c = 9'h008;
      default:   c = 9'h100;
    endcase
    return c;
  endfunction

  function automatic res_pack_t single(input logic [7:0] b, input kind_t k);
    res_pack_t p;
    p.n     = 3'd1;
    p.bytes = '0;
    p.bytes[0] = b;
    p.kind  = k;
    return p;
  endfunction

  function automatic res_pack_t utf8_pack(input logic [20:0] cp);
    res_pack_t p;
    p.n     = 3'd0;
    p.bytes = '0;
    p.kind  = KIND_DATA;
    priority if (cp == 21'd0) begin
      p.n = 3'd0;
    end else if (cp <= 21'h7F) begin
      p.n = 3'd1;
      p.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      p.n = 3'd2;
      p.bytes[0] = 8'hC0 | {3'b0, cp[10:6]};
      p.bytes[1] = 8'h80 | {2'b0, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      p.n = 3'd3;
      p.bytes[0] = 8'hE0 | {4'b0, cp[15:12]};
      p.bytes[1] = 8'h80 | {2'b0, cp[11:6]};
      p.bytes[2] = 8'h80 | {2'b0, cp[5:0]};
    end else if (cp <= CP_MAX) begin
      p.n = 3'd4;
      p.bytes[0] = 8'hF0 | {5'b0, cp[20:18]};
      p.bytes[1] = 8'h80 | {2'b0, cp[17:12]};
      p.bytes[2] = 8'h80 | {2'b0, cp[11:6]};
      p.bytes[3] = 8'h80 | {2'b0, cp[5:0]};
    end else begin
      p.n = 3'd0;
    end
    return p;
  endfunction

endpackage

/* hdl/jsu_in_if.sv */
`timescale 1ns / 1ps

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_end;

  modport source (output valid, output in_byte, output in_end, input ready);
  modport sink (input valid, input in_byte, input in_end, output ready);
endinterface

/* hdl/jsu_out_if.sv */
`timescale 1ns / 1ps

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] out_kind;
  logic       out_last;

  modport source (output valid, output out_byte, output out_kind, output out_last,
                  input ready);
  modport sink (input valid, input out_byte, input out_kind, input out_last,
                output ready);
endinterface

/* hdl/jsu_decode.sv */
`timescale 1ns / 1ps
`include "json_string_unescape_utf8_defines.svh"

module jsu_decode import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  jsu_in_if.sink    in_ch,
  input  logic      buf_free,
  output logic      load,
  output res_pack_t pack
);

  logic        iv;
  logic [7:0]  ib;
  logic        ie;
  logic        fire;

  mode_t       mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] code_acc, code_acc_next;
  logic [9:0]  high_part, high_part_next;

  logic [4:0]  h;
  logic [8:0]  ec;
  logic [15:0] acc_shift;
  logic [20:0] cp_pair;

  assign fire        = iv && buf_free;
  assign in_ch.ready = !iv || fire;
  assign load        = fire && (pack.n != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      iv <= 1'b1;
    end else if (fire) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      ib <= in_ch.in_byte;
      ie <= in_ch.in_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_NORMAL;
      hex_count <= 2'd0;
      code_acc  <= 16'd0;
      high_part <= 10'd0;
    end else if (fire) begin
      mode      <= mode_next;
      hex_count <= hex_count_next;
      code_acc  <= code_acc_next;
      high_part <= high_part_next;
    end
  end

  assign h         = hex_val(ib);
  assign ec        = esc_char(ib);
  assign acc_shift = {code_acc[11:0], h[3:0]};
  assign cp_pair   = SUPP_BASE + {1'b0, high_part, acc_shift[9:0]};

  always_comb begin
    mode_next      = mode;
    hex_count_next = hex_count;
    code_acc_next  = code_acc;
    high_part_next = high_part;
    pack.n         = 3'd0;
    pack.bytes     = '0;
    pack.kind      = KIND_DATA;
    if (ie) begin
      if (mode < MODE_DONE) begin
        pack = single(8'd0, KIND_UNTERM);
      end
      mode_next      = MODE_NORMAL;
      hex_count_next = 2'd0;
      code_acc_next  = 16'd0;
      high_part_next = 10'd0;
    end else begin
      unique case (mode)
        MODE_NORMAL: begin
          if (ib == CH_QUOTE) begin
            pack      = single(8'd0, KIND_CLOSED);
            mode_next = MODE_DONE;
          end else if (ib == CH_BSLASH) begin
            mode_next = MODE_ESC;
          end else begin
            pack = single(ib, KIND_DATA);
          end
        end
        MODE_ESC: begin
          if (ib == CH_U) begin
            mode_next      = MODE_HEX1;
            hex_count_next = 2'd0;
            code_acc_next  = 16'd0;
          end else if (ec[8]) begin
            pack      = single(8'd0, KIND_BAD_ESC);
            mode_next = MODE_DONE;
          end else begin
            pack      = single(ec[7:0], KIND_DATA);
            mode_next = MODE_NORMAL;
          end
        end
        MODE_HEX1, MODE_HEX2: begin
          if (h[4]) begin
            pack      = single(8'd0, KIND_BAD_HEX);
            mode_next = MODE_DONE;
          end else if (hex_count != 2'd3) begin
            code_acc_next  = acc_shift;
            hex_count_next = hex_count + 2'd1;
          end else begin
            hex_count_next = 2'd0;
            code_acc_next  = 16'd0;
            if (mode == MODE_HEX1) begin
              if (acc_shift >= HIGH_SURR_LO && acc_shift <= HIGH_SURR_HI) begin
                high_part_next = acc_shift[9:0];
                mode_next      = MODE_WANT_BS;
              end else begin
                pack      = utf8_pack({5'd0, acc_shift});
                mode_next = MODE_NORMAL;
              end
            end else begin
              pack           = utf8_pack(cp_pair);
              high_part_next = 10'd0;
              mode_next      = MODE_NORMAL;
            end
          end
        end
        MODE_WANT_BS: begin
          if (ib == CH_BSLASH) begin
            mode_next = MODE_WANT_U;
          end else begin
            pack      = single(8'd0, KIND_NO_LOW);
            mode_next = MODE_DONE;
          end
        end
        MODE_WANT_U: begin
          if (ib == CH_U) begin
            mode_next      = MODE_HEX2;
            hex_count_next = 2'd0;
            code_acc_next  = 16'd0;
          end else begin
            pack      = single(8'd0, KIND_NO_LOW);
            mode_next = MODE_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `JSU_ASSERT_NXT(a_end_clears, fire && ie,
    mode == MODE_NORMAL && hex_count == 2'd0 && code_acc == 16'd0 && high_part == 10'd0,
    "end of buffer did not clear state")
  `JSU_ASSERT_IMP(a_hex_count_mode, hex_count != 2'd0,
    mode == MODE_HEX1 || mode == MODE_HEX2 || mode == MODE_DONE,
    "hex digits pending outside a hex escape")

endmodule

/* hdl/jsu_out_buf.sv */
`timescale 1ns / 1ps
`include "json_string_unescape_utf8_defines.svh"

module jsu_out_buf import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  res_pack_t pack,
  output logic      buf_free,
  jsu_out_if.source out_ch
);

  logic            busy;
  logic [1:0]      idx;
  logic [2:0]      n_r;
  logic [3:0][7:0] bytes;
  kind_t           kind;
  logic            last;

  assign last            = ({1'b0, idx} == (n_r - 3'd1));
  assign out_ch.valid    = busy;
  assign out_ch.out_byte = bytes[idx];
  assign out_ch.out_kind = kind;
  assign out_ch.out_last = last;
  assign buf_free        = !busy || (out_ch.ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (busy && out_ch.ready) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      n_r   <= pack.n;
      bytes <= pack.bytes;
      kind  <= pack.kind;
    end
  end

  `JSU_ASSERT_IMP(a_idx_in_range, busy, {1'b0, idx} < n_r, "output index beyond result count")
  `JSU_ASSERT_IMP(a_status_alone, busy && kind != KIND_DATA, n_r == 3'd1 && idx == 2'd0, "status result not alone")

endmodule

/* hdl/json_string_unescape_utf8.sv */
`timescale 1ns / 1ps
// JSON string body decoder: one raw byte per transfer on in_ch (in_end marks
// end of buffer), decoded UTF-8 bytes and status results on out_ch, with
// out_last on the final result of each input byte. Throughput is one input
// byte per cycle while out_ch is ready and that byte yields zero or one
// result; a \u escape that completes into a k-byte UTF-8 sequence (k = 2..4)
// holds the output register while its k bytes drain; input waits behind it.
// The output serializer sends one result per cycle while out_ch is ready.
// A result passes the input register, then the result register, to out_ch.
// After a closing quote or an error nothing further is produced until in_end.

module json_string_unescape_utf8 import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  logic      buf_free;
  logic      load;
  res_pack_t pack;

  jsu_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .buf_free (buf_free),
    .load     (load),
    .pack     (pack)
  );

  jsu_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .pack     (pack),
    .buf_free (buf_free),
    .out_ch   (out_ch)
  );

endmodule
